// ----- design/tup_pkg.sv -----
package tup_pkg;

  localparam int WORD_BITS = 64;
  localparam int HEX_LIMIT = WORD_BITS / 4;
  localparam int CNT_BITS  = 5;
  localparam logic [CNT_BITS-1:0] CNT_SAT = CNT_BITS'(HEX_LIMIT + 1);

  localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] OCT_RLIM  = WORD_MASK / 8;
  localparam logic [WORD_BITS-1:0] OCT_DLIM  = WORD_MASK - OCT_RLIM * 8;
  localparam logic [WORD_BITS-1:0] DEC_RLIM  = WORD_MASK / 10;
  localparam logic [WORD_BITS-1:0] DEC_DLIM  = WORD_MASK - DEC_RLIM * 10;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [3:0] OCT_RADIX = 4'd8;
  localparam logic [3:0] DEC_RADIX = 4'd10;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_NONHEX   = 3'd2,
    ERR_HEXLONG  = 3'd3,
    ERR_NONDIGIT = 3'd4,
    ERR_OVERFLOW = 3'd5,
    ERR_TOOLARGE = 3'd6
  } err_t;

  typedef enum logic {
    REG_BASE_MODE   = 1'b0,
    REG_UPPER_BOUND = 1'b1
  } reg_idx_t;

  // End-of-string summary handed from the scanner to the bound check.
  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    err_t                 err;
    logic                 hex_long;
  } fin_t;

endpackage

// ----- design/tup_char_if.sv -----
interface tup_char_if;
  import tup_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       empty_req;

  modport source (output valid, ch, last, empty_req, input ready);
  modport sink   (input valid, ch, last, empty_req, output ready);

endinterface

// ----- design/tup_result_if.sv -----
interface tup_result_if;
  import tup_pkg::*;

  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  error_code;

  modport source (output valid, value, error_code, input ready);
  modport sink   (input valid, value, error_code, output ready);

endinterface

// ----- design/tup_scan.sv -----
module tup_scan import tup_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  base_t      base_mode,
  input  logic       char_valid,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       empty_req,
  output logic       fin_valid,
  output fin_t       fin
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ZERO  = 2'd1,
    PH_ZX    = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  // input register
  logic       v1;
  logic [7:0] ch1;
  logic       last1;
  logic       empty1;

  // per-string state
  phase_t               phase;
  base_t                base_in_use;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  hex_cnt;
  err_t                 err;

  phase_t               phase_next;
  base_t                base_next;
  logic [WORD_BITS-1:0] acc_next;
  logic [CNT_BITS-1:0]  hex_cnt_next;
  err_t                 err_next;
  logic                 take;

  logic [3:0]           hex_d;
  logic                 hex_ok;
  logic [7:0]           dig;
  logic                 dig_ok;
  logic [WORD_BITS-1:0] rlim;
  logic [WORD_BITS-1:0] dlim;
  logic [WORD_BITS-1:0] scaled;

  always_comb begin
    phase_next = phase;
    base_next  = base_in_use;
    take       = 1'b1;
    case (phase)
      PH_START: begin
        if (base_mode != BASE_AUTO) begin
          base_next  = base_mode;
          phase_next = PH_BODY;
        end else if (ch1 == CH_ZERO && !last1) begin
          phase_next = PH_ZERO;
          take       = 1'b0;
        end else begin
          base_next  = BASE_DEC;
          phase_next = PH_BODY;
        end
      end
      PH_ZERO: begin
        if ((ch1 == CH_X_LO || ch1 == CH_X_UP) && !last1) begin
          phase_next = PH_ZX;
          take       = 1'b0;
        end else begin
          base_next  = BASE_OCT;
          phase_next = PH_BODY;
        end
      end
      PH_ZX: begin
        base_next  = BASE_HEX;
        phase_next = PH_BODY;
      end
      default: begin
        phase_next = PH_BODY;
      end
    endcase
  end

  // digit decode
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (ch1 >= CH_ZERO && ch1 <= CH_NINE) begin
      hex_d = 4'(ch1 - CH_ZERO);
    end else if (ch1 >= CH_A_LO && ch1 <= CH_F_LO) begin
      hex_d = 4'(ch1 - CH_A_LO + 8'd10);
    end else if (ch1 >= CH_A_UP && ch1 <= CH_F_UP) begin
      hex_d = 4'(ch1 - CH_A_UP + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign dig    = ch1 - CH_ZERO;
  assign dig_ok = (ch1 >= CH_ZERO) &&
                  (dig < {4'd0, (base_next == BASE_OCT) ? OCT_RADIX : DEC_RADIX});
  assign rlim   = (base_next == BASE_OCT) ? OCT_RLIM : DEC_RLIM;
  assign dlim   = (base_next == BASE_OCT) ? OCT_DLIM : DEC_DLIM;
  assign scaled = (base_next == BASE_OCT) ? (acc << 3) : ((acc << 3) + (acc << 1));

  // accumulate one digit; errors latch and later characters are dropped
  always_comb begin
    acc_next     = acc;
    hex_cnt_next = hex_cnt;
    err_next     = err;
    if (take && err == ERR_NONE) begin
      if (base_next == BASE_HEX) begin
        if (!hex_ok) begin
          err_next = ERR_NONHEX;
        end else begin
          acc_next = {acc[WORD_BITS-5:0], hex_d};
          if (hex_cnt < CNT_SAT) begin
            hex_cnt_next = hex_cnt + 1'b1;
          end
        end
      end else begin
        if (!dig_ok) begin
          err_next = ERR_NONDIGIT;
        end else if (acc > rlim || (acc == rlim && {{(WORD_BITS-8){1'b0}}, dig} > dlim)) begin
          err_next = ERR_OVERFLOW;
        end else begin
          acc_next = scaled + {{(WORD_BITS-8){1'b0}}, dig};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      phase       <= PH_START;
      base_in_use <= BASE_AUTO;
      acc         <= '0;
      hex_cnt     <= '0;
      err         <= ERR_NONE;
      fin_valid   <= 1'b0;
    end else if (advance) begin
      v1        <= char_valid;
      fin_valid <= v1 && (last1 || empty1);
      if (v1) begin
        if (last1 || empty1) begin
          phase       <= PH_START;
          base_in_use <= BASE_AUTO;
          acc         <= '0;
          hex_cnt     <= '0;
          err         <= ERR_NONE;
        end else begin
          phase       <= phase_next;
          base_in_use <= base_next;
          acc         <= acc_next;
          hex_cnt     <= hex_cnt_next;
          err         <= err_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      ch1    <= ch;
      last1  <= last;
      empty1 <= empty_req;
      if (empty1) begin
        fin.value    <= '0;
        fin.err      <= ERR_EMPTY;
        fin.hex_long <= 1'b0;
      end else begin
        fin.value    <= acc_next;
        fin.err      <= err_next;
        fin.hex_long <= (base_next == BASE_HEX) &&
                        (hex_cnt_next > CNT_BITS'(HEX_LIMIT));
      end
    end
  end

endmodule

// ----- design/tup_check.sv -----
module tup_check import tup_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          upper_bound,
  input  logic                 fin_valid,
  input  fin_t                 fin,
  output logic                 advance,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [63:0]          value,
  output err_t                 error_code
);

  err_t        err_next;
  logic [63:0] wide;

  assign wide    = 64'(fin.value);
  assign advance = !res_valid || res_ready;

  always_comb begin
    err_next = fin.err;
    if (fin.err == ERR_NONE) begin
      if (fin.hex_long) begin
        err_next = ERR_HEXLONG;
      end else if (wide > upper_bound) begin
        err_next = ERR_TOOLARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      error_code <= err_next;
      value      <= (err_next == ERR_NONE) ? wide : 64'd0;
    end
  end

endmodule

// ----- design/text_to_unsigned_parser_top.sv -----
// Streaming text-to-unsigned parser: one character transfer per cycle unless the result stalls.
// The result for a string passes the input register, the digit/state update register
// and the bound check register after the transfer of its last character.
// The character rate is bounded by the combinational accumulate loop: acc*base + digit and compare.
// Reset (rst, synchronous, active high) empties all stages, clears the per-string
// state, sets base_mode to auto-detect and upper_bound to all ones.
module text_to_unsigned_parser_top import tup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  tup_char_if.sink    text,
  tup_result_if.source result
);

  base_t       base_mode;
  logic [63:0] upper_bound;

  logic        advance;
  logic        fin_valid;
  fin_t        fin;
  err_t        err_code;

  // Configuration registers; the user writes them only while the pipeline is drained (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode   <= BASE_AUTO;
      upper_bound <= '1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_MODE:   base_mode   <= base_t'(cfg_data[1:0]);
        REG_UPPER_BOUND: upper_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together: advance whenever the result register is
  // empty or its content is being taken, so a new character transfer can land in
  // the same cycle a finished result leaves.
  assign text.ready = advance;

  // Stage 1 and 2: hold the character, then run prefix detection and digit
  // accumulation, and emit the string summary on the last character or an
  // empty request.
  tup_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .base_mode  (base_mode),
    .char_valid (text.valid),
    .ch         (text.ch),
    .last       (text.last),
    .empty_req  (text.empty_req),
    .fin_valid  (fin_valid),
    .fin        (fin)
  );

  // Stage 3: apply the hex length rule and the upper bound, zero the value on
  // error, and hold the result until transfer.
  tup_check u_check (
    .clk         (clk),
    .rst         (rst),
    .upper_bound (upper_bound),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .advance     (advance),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .value       (result.value),
    .error_code  (err_code)
  );

  assign result.error_code = err_code;

endmodule

// ----- sim/text_to_unsigned_parser_top_test.sv -----
`timescale 1ns / 1ps

module text_to_unsigned_parser_top_test;
  import tup_pkg::*;

  localparam int          QUIET_LIMIT    = 1000;  // cycles without any transfer
  localparam int          SETTLE_CYCLES  = 4;     // drain margin after the last result
  localparam int          HEX_DIGITS_MAX = 64 / 4;
  localparam logic [63:0] ALL_ONES       = '1;

  localparam logic [7:0] CHAR_0     = "0";
  localparam logic [7:0] CHAR_9     = "9";
  localparam logic [7:0] CHAR_A_LO  = "a";
  localparam logic [7:0] CHAR_F_LO  = "f";
  localparam logic [7:0] CHAR_A_UP  = "A";
  localparam logic [7:0] CHAR_F_UP  = "F";
  localparam logic [7:0] CHAR_X_LO  = "x";
  localparam logic [7:0] CHAR_X_UP  = "X";

  // Where the scanner stands within the current string.
  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_LEAD_ZERO,
    SCAN_ZERO_X,
    SCAN_BODY
  } scan_phase_t;

  typedef struct {
    logic [63:0] value;
    err_t        err;
  } parse_result_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  reg_idx_t cfg_index;
  logic [63:0] cfg_data;

  tup_char_if   text_bus();
  tup_result_if result_bus();

  text_to_unsigned_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text_bus),
    .result    (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, updated by set_config.
  base_t       cfg_base  = BASE_AUTO;
  logic [63:0] cfg_bound = ALL_ONES;

  // Shadow copy of the per-string scanner state.
  scan_phase_t scan_phase;
  base_t       body_base;
  logic [63:0] acc;
  logic [4:0]  hex_cnt;
  err_t        sticky_err;

  parse_result_t pending_results[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int sent_chars   = 0;
  int stall_left   = 0;
  bit idle_on      = 1'b1;

  // ---------------------------------------------------------------------------
  // Expected-result computation
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_phase = SCAN_START;
    body_base  = BASE_AUTO;
    acc        = '0;
    hex_cnt    = '0;
    sticky_err = ERR_NONE;
  endfunction

  // Fold one character into the body. Once an error is latched, the rest of
  // the string is swallowed without effect.
  function automatic void absorb_digit(logic [7:0] c);
    logic [63:0] digit;
    logic [63:0] radix;
    logic [63:0] row_lim;
    logic [63:0] digit_lim;
    if (sticky_err != ERR_NONE) return;
    if (body_base == BASE_HEX) begin
      if (c >= CHAR_0 && c <= CHAR_9) begin
        digit = c - CHAR_0;
      end else if (c >= CHAR_A_LO && c <= CHAR_F_LO) begin
        digit = c - CHAR_A_LO + 10;
      end else if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
        digit = c - CHAR_A_UP + 10;
      end else begin
        sticky_err = ERR_NONHEX;
        return;
      end
      // Hex wraps within the word; length is judged at the end of the string.
      acc = {acc[59:0], digit[3:0]};
      if (hex_cnt < HEX_DIGITS_MAX + 1) hex_cnt++;
    end else begin
      radix     = (body_base == BASE_OCT) ? 64'd8 : 64'd10;
      row_lim   = ALL_ONES / radix;
      digit_lim = ALL_ONES - row_lim * radix;
      // Below '0' the subtraction wraps to a huge number, so one compare covers it.
      digit = c - CHAR_0;
      if (digit >= radix) begin
        sticky_err = ERR_NONDIGIT;
        return;
      end
      if (acc > row_lim || (acc == row_lim && digit > digit_lim)) begin
        sticky_err = ERR_OVERFLOW;
        return;
      end
      acc = acc * radix + digit;
    end
  endfunction

  function automatic void parse_char(logic [7:0] c, logic last, logic empty_req);
    err_t e;
    if (empty_req) begin
      // Abandon any partial string.
      clear_scan();
      pending_results.push_back('{value: '0, err: ERR_EMPTY});
      return;
    end
    case (scan_phase)
      SCAN_START: begin
        if (cfg_base != BASE_AUTO) begin
          body_base  = cfg_base;
          scan_phase = SCAN_BODY;
          absorb_digit(c);
        end else if (c == CHAR_0 && !last) begin
          scan_phase = SCAN_LEAD_ZERO;
        end else begin
          body_base  = BASE_DEC;
          scan_phase = SCAN_BODY;
          absorb_digit(c);
        end
      end
      SCAN_LEAD_ZERO: begin
        if ((c == CHAR_X_LO || c == CHAR_X_UP) && !last) begin
          scan_phase = SCAN_ZERO_X;
        end else begin
          body_base  = BASE_OCT;
          scan_phase = SCAN_BODY;
          absorb_digit(c);
        end
      end
      SCAN_ZERO_X: begin
        body_base  = BASE_HEX;
        scan_phase = SCAN_BODY;
        absorb_digit(c);
      end
      default: absorb_digit(c);
    endcase
    if (!last) return;
    e = sticky_err;
    if (e == ERR_NONE && body_base == BASE_HEX && hex_cnt > HEX_DIGITS_MAX) e = ERR_HEXLONG;
    if (e == ERR_NONE && acc > cfg_bound) e = ERR_TOOLARGE;
    pending_results.push_back('{value: (e == ERR_NONE) ? acc : '0, err: e});
    clear_scan();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void compare_result();
    parse_result_t exp;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result value %0h error %0d",
                              result_bus.value, result_bus.error_code));
      return;
    end
    exp = pending_results.pop_front();
    if (result_bus.value !== exp.value)
      flag_mismatch($sformatf("value expected %0h, got %0h", exp.value, result_bus.value));
    if (result_bus.error_code !== exp.err)
      flag_mismatch($sformatf("error code expected %0d, got %0d",
                              exp.err, result_bus.error_code));
  endfunction

  // Sample both channels at the edge: predict from each accepted character,
  // check each accepted result, and keep the watchdog running.
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      quiet_cycles <= 0;
    end else begin
      if (text_bus.valid && text_bus.ready)
        parse_char(text_bus.ch, text_bus.last, text_bus.empty_req);
      if (result_bus.valid && result_bus.ready)
        compare_result();
      if ((text_bus.valid && text_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result sink: drop ready in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left        <= stall_left - 1;
      result_bus.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left        <= $urandom_range(0, 11);
      result_bus.ready  <= 1'b0;
    end else begin
      result_bus.ready  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one character and hold it until the transfer. Entered and left at a
  // rising edge; an idle burst lowers valid first, so valid never drops and
  // rises within the same step.
  task automatic send_item(input logic [7:0] c, input logic last, input logic empty_req);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    text_bus.valid     <= 1'b1;
    text_bus.ch        <= c;
    text_bus.last      <= last;
    text_bus.empty_req <= empty_req;
    @(posedge clk);
    while (!text_bus.ready) @(posedge clk);
    sent_chars++;
  endtask

  // Send a whole string; an empty one becomes an empty request. With abandon
  // set, the string is cut off by an empty request instead of a last marker.
  task automatic send_bytes(input logic [7:0] txt[$], input bit abandon);
    for (int i = 0; i < txt.size(); i++)
      send_item(txt[i], !abandon && i == txt.size() - 1, 1'b0);
    if (txt.size() == 0 || abandon)
      send_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic send_str(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_bytes(txt, 1'b0);
  endtask

  // Drop valid, wait until every expected result has arrived, then let the
  // pipeline drain before touching the registers.
  task automatic settle();
    text_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only called while idle.
  task automatic set_config(input base_t mode, input logic [63:0] bound);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE_MODE;
    cfg_data  <= 64'(mode);
    @(posedge clk);
    cfg_index <= REG_UPPER_BOUND;
    cfg_data  <= bound;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_base  = mode;
    cfg_bound = bound;
  endtask

  // Build a well-formed number for the current base mode, biased toward the
  // interesting values: extremes, the overflow boundary and long hex strings.
  function automatic string make_number();
    base_t       b;
    string       s;
    logic [63:0] v;
    int          pick;
    int          pad;
    b    = (cfg_base == BASE_AUTO) ? base_t'($urandom_range(1, 3)) : cfg_base;
    pick = $urandom_range(0, 5);
    case (pick)
      0:       v = $urandom_range(0, 999);
      1:       v = {$urandom, $urandom};
      2:       v = {$urandom, $urandom} >> $urandom_range(1, 63);
      3:       v = ALL_ONES - $urandom_range(0, 3);
      default: v = (b == BASE_OCT) ? ALL_ONES / 8 : ALL_ONES / 10;
    endcase
    case (b)
      BASE_OCT: s = $sformatf("%0o", v);
      BASE_DEC: s = $sformatf("%0d", v);
      default:  s = $sformatf("%0h", v);
    endcase
    // One more digit past the row limit lands right on the overflow edge.
    if (pick == 4) s = {s, string'(8'(CHAR_0 + $urandom_range(0, 9)))};
    // Leading zeros: pick 5 pads to the hex length limit and just past it.
    pad = (pick == 5) ? HEX_DIGITS_MAX - s.len() + $urandom_range(0, 1)
        : ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (pad) s = {"0", s};
    if (b == BASE_HEX && $urandom_range(0, 1)) s = s.toupper();
    if (cfg_base == BASE_AUTO) begin
      if (b == BASE_HEX) begin
        if ($urandom_range(0, 1) != 0) s = {"0x", s};
        else s = {"0X", s};
      end else if (b == BASE_OCT) begin
        s = {"0", s};
      end
    end else if ($urandom_range(0, 7) == 0) begin
      s = {"0x", s};
    end
    return s;
  endfunction

  // Mostly well-formed numbers; the rest is empty requests, raw noise,
  // corrupted numbers and strings cut off by an empty request.
  task automatic send_random_string();
    logic [7:0] txt[$];
    string      s;
    int         kind;
    kind = $urandom_range(0, 19);
    if (kind >= 1 && kind <= 2) begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom));
    end else if (kind != 0) begin
      s = make_number();
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      if (kind == 3) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
    end
    send_bytes(txt, kind == 4);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Auto-detect right after reset: lone zero, "0x" with nothing after it,
  // an uppercase hex prefix with a lowercase digit, an octal string and a plain digit.
  task automatic test_auto_prefixes();
    send_str("0");
    send_str("0x");
    send_str("0X1f");
    send_str("017");
    send_str("7");
    settle();
  endtask

  // Empty request alone and mid-string, characters after an error,
  // and bytes outside the printable range.
  task automatic test_special_inputs();
    send_item(8'hA5, 1'b0, 1'b1);
    send_item("5", 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_str("a5");
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    settle();
  endtask

  // Fixed hex does not strip a prefix, so the 'x' is a bad hex digit.
  task automatic test_fixed_hex();
    set_config(BASE_HEX, ALL_ONES);
    send_str("0x");
    send_str("Ff");
    settle();
  endtask

  // A valid value one above the bound is rejected, the bound itself passes.
  task automatic test_upper_bound();
    set_config(BASE_DEC, 64'd9);
    send_str("10");
    send_str("9");
    settle();
  endtask

  // Random strings over several register settings, extremes included.
  // The last phase runs with no idling on either side.
  task automatic test_random_strings();
    logic [63:0] bound;
    base_t       mode;
    int          goal;
    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       bound = '0;
        2:       bound = $urandom_range(0, 5000);
        3:       bound = {$urandom, $urandom} >> $urandom_range(0, 40);
        default: bound = ALL_ONES;
      endcase
      mode = (p < 4) ? base_t'(p) : base_t'($urandom_range(0, 3));
      if (p == 5) idle_on = 1'b0;
      set_config(mode, bound);
      goal = sent_chars + 100;
      while (sent_chars < goal) send_random_string();
      settle();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_BASE_MODE;
    cfg_data           <= '0;
    text_bus.valid     <= 1'b0;
    text_bus.ch        <= '0;
    text_bus.last      <= 1'b0;
    text_bus.empty_req <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_auto_prefixes();
    test_special_inputs();
    test_fixed_hex();
    test_upper_bound();
    test_random_strings();

    // Catch any stray result that shows up late.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
